FILE: hdl/dmec_pkg.sv
// Shared constants and types of the direct-mapped evaluation cache.
`default_nettype none

package dmec_pkg;

	localparam int BUCKETS    = 256;
	localparam int MOVES      = 384;
	localparam int HASH_W     = 64;
	localparam int SIZE_W     = 9;
	localparam int MC_W       = 9;
	localparam int IDX_W      = 9;
	localparam int WORD_W     = 32;
	localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int POL_DEPTH  = BUCKETS * MOVES;
	localparam int POL_AW     = (POL_DEPTH > 1) ? $clog2(POL_DEPTH) : 1;
	localparam int MOD_DIGITS = 8;
	localparam int MOD_CYCLES = HASH_W / MOD_DIGITS;
	localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

	typedef enum logic [1:0] {
		FN_LOOKUP  = 2'd0,
		FN_INS_HDR = 2'd1,
		FN_INS_POL = 2'd2,
		FN_CLEAR   = 2'd3
	} func_t;

	typedef struct packed {
		func_t               func;
		logic [HASH_W-1:0]   position_hash;
		logic [MC_W-1:0]     move_count;
		logic [WORD_W-1:0]   value_q;
		logic [WORD_W-1:0]   value_d;
		logic [WORD_W-1:0]   value_m;
		logic [IDX_W-1:0]    policy_index;
		logic [WORD_W-1:0]   policy_word;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [WORD_W-1:0]   found_q;
		logic [WORD_W-1:0]   found_d;
		logic [WORD_W-1:0]   found_m;
		logic [WORD_W-1:0]   found_policy;
		logic                policy_present;
	} rsp_t;

	typedef struct packed {
		logic [HASH_W-1:0]   tag;
		logic [MC_W-1:0]     count;
		logic [WORD_W-1:0]   q;
		logic [WORD_W-1:0]   d;
		logic [WORD_W-1:0]   m;
	} hdr_t;

endpackage

`default_nettype wire

FILE: hdl/dmec_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dmec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/dmec_mod.sv
// Iterative remainder unit: 64-bit hash modulo bucket count, several bits per cycle.
`default_nettype none

module dmec_mod import dmec_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [HASH_W-1:0] dividend,
	input  wire logic [SIZE_W-1:0] divisor,
	output logic                   done,
	output logic      [SIZE_W-1:0] remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [HASH_W-1:0]    dvd_q;
	logic [SIZE_W-1:0]    div_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [SIZE_W:0]      rem_next;

	always_comb begin
		rem_next = {1'b0, rem_q};
		for (int i = 0; i < MOD_DIGITS; i++) begin
			rem_next = {rem_next[SIZE_W-1:0], dvd_q[HASH_W-1-i]};
			if (rem_next >= {1'b0, div_q}) begin
				rem_next = rem_next - {1'b0, div_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_DIGITS;
			rem_q <= rem_next[SIZE_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

FILE: hdl/direct_mapped_eval_cache_top.sv
// Top level of the direct-mapped evaluation cache: sequencer, stores and result register.
//
// One transaction is processed at a time. Lookups and inserts first reduce the 64-bit
// hash modulo the bucket count in the remainder unit, which retires eight hash bits per
// cycle, then read or write the header RAM and the policy RAM. A lookup result is
// registered after the division and access states, and the next transaction can be
// accepted in the cycle after that; an insert stalls the input through the division
// and access states, and a clear is taken without leaving the idle state. The result
// register lets the next transaction be accepted while a result waits; a lookup that
// finishes while that result is still stalled holds until it leaves. After reset the
// header RAM is zeroed in a pass over all its buckets, during which no transaction or
// size write is taken. A pending size write takes priority over a request in the same
// cycle. Clear and any size write drop every bucket's valid bit at once; an invalid
// bucket reads as zero tag and count, and its value words are kept.
`default_nettype none

module direct_mapped_eval_cache_top import dmec_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [SIZE_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIV,
		ST_ACCESS,
		ST_LOOKUP
	} state_t;

	state_t                    state_q;
	logic [BKT_W-1:0]          init_q;
	req_t                      req_q;
	logic [BKT_W-1:0]          bucket_q;
	logic [SIZE_W-1:0]         size_q;
	logic [BUCKETS-1:0]        valid_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	logic [SIZE_W-1:0]         size_eff;
	logic                      size_zero;
	logic                      req_take;
	logic                      cfg_take;
	logic                      mod_start;
	logic                      mod_done;
	logic [SIZE_W-1:0]         mod_rem;
	logic                      pidx_ok;
	logic [POL_AW-1:0]         pol_addr;
	hdr_t                      hdr_wr;
	hdr_t                      hdr_wdata;
	logic [BKT_W-1:0]          hdr_waddr;
	logic                      hdr_wen;
	hdr_t                      hdr_rd;
	logic [$bits(hdr_t)-1:0]   hdr_rd_raw;
	logic                      hdr_we;
	logic                      hdr_re;
	logic                      pol_we;
	logic                      pol_re;
	logic [WORD_W-1:0]         pol_rd;
	logic                      rsp_free;
	logic [MC_W-1:0]           cap;
	logic                      entry_valid;
	logic [HASH_W-1:0]         tag_eff;
	logic [MC_W-1:0]           cnt_eff;
	rsp_t                      rsp_next;

	assign size_eff  = (int'(size_q) > BUCKETS) ? SIZE_W'(BUCKETS) : size_q;
	assign size_zero = (size_eff == '0);
	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign req_take  = req_valid && !req_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_take  = cfg_valid && cfg_ready;
	assign mod_start = req_take && (req.func != FN_CLEAR);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	dmec_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (req.position_hash),
		.divisor   (size_eff),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign pidx_ok  = (int'(req_q.policy_index) < MOVES);
	assign pol_addr = pidx_ok ?
		POL_AW'(bucket_q) * POL_AW'(MOVES) + POL_AW'(req_q.policy_index) : '0;

	assign hdr_we = (state_q == ST_ACCESS) && (req_q.func == FN_INS_HDR) && !size_zero;
	assign pol_we = (state_q == ST_ACCESS) && (req_q.func == FN_INS_POL) && !size_zero
		&& pidx_ok;
	assign hdr_re = (state_q == ST_ACCESS) && (req_q.func == FN_LOOKUP);
	assign pol_re = hdr_re && pidx_ok;

	assign hdr_wr = '{
		tag:   req_q.position_hash,
		count: req_q.move_count,
		q:     req_q.value_q,
		d:     req_q.value_d,
		m:     req_q.value_m
	};

	assign hdr_wen   = hdr_we || (state_q == ST_INIT);
	assign hdr_waddr = (state_q == ST_INIT) ? init_q : bucket_q;
	assign hdr_wdata = (state_q == ST_INIT) ? hdr_t'('0) : hdr_wr;

	dmec_ram #(
		.WIDTH ($bits(hdr_t)),
		.DEPTH (BUCKETS),
		.AW    (BKT_W)
	) u_hdr_ram (
		.clk     (clk),
		.wr_en   (hdr_wen),
		.wr_addr (hdr_waddr),
		.wr_data (hdr_wdata),
		.rd_en   (hdr_re),
		.rd_addr (bucket_q),
		.rd_data (hdr_rd_raw)
	);

	dmec_ram #(
		.WIDTH (WORD_W),
		.DEPTH (POL_DEPTH),
		.AW    (POL_AW)
	) u_pol_ram (
		.clk     (clk),
		.wr_en   (pol_we),
		.wr_addr (pol_addr),
		.wr_data (req_q.policy_word),
		.rd_en   (pol_re),
		.rd_addr (pol_addr),
		.rd_data (pol_rd)
	);

	assign hdr_rd      = hdr_rd_raw;
	assign entry_valid = valid_q[bucket_q];
	assign tag_eff     = entry_valid ? hdr_rd.tag : '0;
	assign cnt_eff     = entry_valid ? hdr_rd.count : '0;
	assign cap         = (int'(req_q.move_count) < MOVES) ? req_q.move_count : MC_W'(MOVES);

	always_comb begin
		rsp_next     = '0;
		rsp_next.hit = !size_zero && (tag_eff == req_q.position_hash)
			&& (cnt_eff == req_q.move_count);
		if (rsp_next.hit) begin
			rsp_next.found_q = hdr_rd.q;
			rsp_next.found_d = hdr_rd.d;
			rsp_next.found_m = hdr_rd.m;
		end
		rsp_next.policy_present = rsp_next.hit && (req_q.policy_index < cap);
		if (rsp_next.policy_present) begin
			rsp_next.found_policy = pol_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			size_q      <= SIZE_W'(BUCKETS);
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if ((state_q == ST_LOOKUP) && rsp_free) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_next;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_take) begin
				size_q  <= cfg_data;
				valid_q <= '0;
			end
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						if (req.func == FN_CLEAR) begin
							valid_q <= '0;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						state_q <= ST_ACCESS;
					end
				end
				ST_ACCESS: begin
					if (hdr_we) begin
						valid_q[bucket_q] <= 1'b1;
					end
					state_q <= (req_q.func == FN_LOOKUP) ? ST_LOOKUP : ST_IDLE;
				end
				ST_LOOKUP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_q <= req;
		end
		if ((state_q == ST_DIV) && mod_done) begin
			bucket_q <= BKT_W'(mod_rem);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: hdl/dmec_chk.sv
// Port-level checker for the evaluation cache and its bind to the top level.
`default_nettype none

module dmec_chk import dmec_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.found_q == '0 && rsp.found_d == '0
			&& rsp.found_m == '0 && !rsp.policy_present)
		else $error("miss carries nonzero fields");

	a_policy_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.policy_present |-> rsp.found_policy == '0)
		else $error("policy word without presence");

	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.func != FN_CLEAR |=> req_stall)
		else $error("new transaction taken while one is in progress");

endmodule

bind direct_mapped_eval_cache_top dmec_chk u_dmec_chk (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench of the direct-mapped evaluation cache with a built-in cache predictor.
`default_nettype none

module testbench;
	import dmec_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 30;
	localparam int POOL        = 12;
	localparam int PIDX_KEEP   = 8;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_LEN    = 400;
	localparam int REPORT_MAX  = 40;

	typedef enum {RX_OPEN, RX_COIN, RX_EVERY3, RX_HEAVY} rx_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data  = '0;

	direct_mapped_eval_cache_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// predicted cache contents
	logic [HASH_W-1:0] tag_mem [BUCKETS]   = '{default: '0};
	logic [MC_W-1:0]   cnt_mem [BUCKETS]   = '{default: '0};
	logic [WORD_W-1:0] q_mem   [BUCKETS]   = '{default: '0};
	logic [WORD_W-1:0] d_mem   [BUCKETS]   = '{default: '0};
	logic [WORD_W-1:0] m_mem   [BUCKETS]   = '{default: '0};
	logic [WORD_W-1:0] pol_mem [POL_DEPTH] = '{default: '0};
	int unsigned       live_size           = BUCKETS;

	// stimulus bookkeeping
	bit                pol_written [POL_DEPTH] = '{default: 1'b0};
	int unsigned       gen_size;
	logic [HASH_W-1:0] pool_hash  [POOL];
	logic [MC_W-1:0]   pool_moves [POOL];
	logic [IDX_W-1:0]  pool_pidx  [POOL][PIDX_KEEP];
	int                pool_np    [POOL];

	req_t        request_q [$];
	rsp_t        answer_q  [$];
	rsp_t        want;
	int unsigned n_queued   = 0;
	int unsigned n_accepted = 0;
	int unsigned n_fail     = 0;
	int unsigned cycles     = 0;
	int          burst_left = 0;
	int          gap_left   = 0;
	int          hold_left  = 0;
	bit          hold_done  = 1'b0;
	rx_mode_t    rx_mode    = RX_OPEN;
	int          rx_left    = 0;
	int unsigned rx_tick    = 0;

	logic [SIZE_W-1:0] size_plan [6] = '{9'd0, 9'd511, 9'd1, 9'd3, 9'd256, 9'd0};
	int                phase_len [6] = '{60, 250, 150, 200, 250, 200};

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned bucket_of(logic [HASH_W-1:0] h, int unsigned n);
		return (n == 0) ? 0 : int'(h % 64'(n));
	endfunction

	function automatic req_t make_txn(func_t f, logic [HASH_W-1:0] h, logic [MC_W-1:0] mc,
			logic [IDX_W-1:0] idx);
		req_t r;
		r.func          = f;
		r.position_hash = h;
		r.move_count    = mc;
		r.value_q       = $urandom;
		r.value_d       = $urandom;
		r.value_m       = $urandom;
		r.policy_index  = idx;
		r.policy_word   = $urandom;
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(int p);
		if (pool_np[p] != 0 && $urandom_range(0, 3) != 0)
			return pool_pidx[p][$urandom_range(0, pool_np[p] - 1)];
		return IDX_W'($urandom_range(0, 511));
	endfunction

	task automatic clear_tags();
		for (int i = 0; i < BUCKETS; i++) begin
			tag_mem[i] = '0;
			cnt_mem[i] = '0;
		end
	endtask

	task automatic cache_apply(input req_t r);
		int unsigned b;
		int unsigned cap;
		rsp_t        a;
		b   = bucket_of(r.position_hash, live_size);
		cap = (r.move_count < MOVES) ? r.move_count : MOVES;
		a   = '0;
		case (r.func)
			FN_CLEAR: clear_tags();
			FN_INS_HDR: begin
				if (live_size != 0) begin
					tag_mem[b] = r.position_hash;
					cnt_mem[b] = r.move_count;
					q_mem[b]   = r.value_q;
					d_mem[b]   = r.value_d;
					m_mem[b]   = r.value_m;
				end
			end
			FN_INS_POL: begin
				if (live_size != 0 && r.policy_index < MOVES)
					pol_mem[b * MOVES + r.policy_index] = r.policy_word;
			end
			FN_LOOKUP: begin
				if (live_size != 0 && tag_mem[b] == r.position_hash
						&& cnt_mem[b] == r.move_count) begin
					a.hit     = 1'b1;
					a.found_q = q_mem[b];
					a.found_d = d_mem[b];
					a.found_m = m_mem[b];
					if (r.policy_index < cap) begin
						a.found_policy   = pol_mem[b * MOVES + r.policy_index];
						a.policy_present = 1'b1;
					end
				end
				answer_q.push_back(a);
			end
			default: begin
			end
		endcase
	endtask

	// keep lookups away from policy words never written
	task automatic queue_txn(input req_t r);
		int unsigned b;
		int unsigned cap;
		b   = bucket_of(r.position_hash, gen_size);
		cap = (r.move_count < MOVES) ? r.move_count : MOVES;
		if (r.func == FN_INS_POL && gen_size != 0 && r.policy_index < MOVES)
			pol_written[b * MOVES + r.policy_index] = 1'b1;
		if (r.func == FN_LOOKUP && r.policy_index < cap
				&& !pol_written[b * MOVES + r.policy_index])
			r.policy_index = IDX_W'(MOVES + $urandom_range(0, 511 - MOVES));
		request_q.push_back(r);
		n_queued++;
	endtask

	task automatic random_phase(input int n_items);
		int unsigned      start;
		int               p;
		int               k;
		int               sel;
		int unsigned      cap;
		logic [MC_W-1:0]  mc;
		logic [IDX_W-1:0] idx;
		for (int i = 0; i < POOL; i++) begin
			pool_hash[i]  = {$urandom, $urandom};
			pool_moves[i] = MC_W'($urandom_range(0, 511));
			pool_np[i]    = 0;
		end
		pool_hash[0] = '0;
		pool_hash[1] = '1;
		pool_hash[2] = 64'($urandom_range(0, 600));
		start = n_queued;
		while (n_queued - start < n_items) begin
			p   = $urandom_range(0, POOL - 1);
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				case ($urandom_range(0, 7))
					0: mc = '0;
					1: mc = '1;
					2: mc = MC_W'(MOVES);
					default: mc = MC_W'($urandom_range(1, 511));
				endcase
				pool_moves[p] = mc;
				pool_np[p]    = 0;
				queue_txn(make_txn(FN_INS_HDR, pool_hash[p], mc, IDX_W'($urandom)));
				cap = (mc < MOVES) ? mc : MOVES;
				k   = (cap == 0) ? 0 : $urandom_range(0, 5);
				repeat (k) begin
					idx = IDX_W'($urandom_range(0, cap - 1));
					if (pool_np[p] < PIDX_KEEP) begin
						pool_pidx[p][pool_np[p]] = idx;
						pool_np[p]++;
					end
					queue_txn(make_txn(FN_INS_POL, pool_hash[p], MC_W'($urandom), idx));
				end
				k = $urandom_range(1, 4);
				repeat (k) queue_txn(make_txn(FN_LOOKUP, pool_hash[p], mc, pick_index(p)));
			end else if (sel < 85) begin
				mc = ($urandom_range(0, 4) == 0) ? MC_W'($urandom) : pool_moves[p];
				queue_txn(make_txn(FN_LOOKUP, pool_hash[p], mc, pick_index(p)));
			end else if (sel < 97) begin
				queue_txn(make_txn(func_t'($urandom_range(0, 2)), {$urandom, $urandom},
					MC_W'($urandom), IDX_W'($urandom)));
			end else begin
				queue_txn(make_txn(FN_CLEAR, {$urandom, $urandom}, MC_W'($urandom),
					IDX_W'($urandom)));
			end
		end
	endtask

	task automatic drain();
		do @(posedge clk); while (n_accepted != n_queued || answer_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		gen_size = (v > BUCKETS) ? BUCKETS : v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string what, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] got_v);
		if (got_v !== want_v) begin
			n_fail++;
			if (n_fail <= REPORT_MAX)
				$display("%0t mismatch %s expected %h actual %h", $time, what, want_v, got_v);
		end
	endtask

	// request driver and predictor update
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				live_size = (cfg_data > BUCKETS) ? BUCKETS : cfg_data;
				clear_tags();
			end
			if (req_valid && !req_stall) begin
				cache_apply(req);
				n_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (request_q.size() != 0) begin
					req       <= request_q.pop_front();
					req_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stall pattern plus one long hold-off
	always @(posedge clk) begin
		rx_tick++;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			rsp_stall <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_OPEN:   rsp_stall <= 1'b0;
				RX_COIN:   rsp_stall <= ($urandom_range(0, 1) == 0);
				RX_EVERY3: rsp_stall <= (rx_tick % 3 == 0);
				RX_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
				default:   rsp_stall <= 1'b0;
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answer_q.size() == 0) begin
				n_fail++;
				if (n_fail <= REPORT_MAX)
					$display("%0t unexpected result, expected none actual %h", $time, rsp);
			end else begin
				want = answer_q.pop_front();
				check_field("hit", want.hit, rsp.hit);
				check_field("found_q", want.found_q, rsp.found_q);
				check_field("found_d", want.found_d, rsp.found_d);
				check_field("found_m", want.found_m, rsp.found_m);
				check_field("found_policy", want.found_policy, rsp.found_policy);
				check_field("policy_present", want.policy_present, rsp.policy_present);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		req_t t;
		arst_n = 1'b0;
		gen_size = BUCKETS;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		queue_txn(make_txn(FN_LOOKUP, '0, 9'd0, 9'd0));
		queue_txn(make_txn(FN_LOOKUP, '0, 9'd1, 9'd0));
		t = make_txn(FN_INS_HDR, '1, 9'd511, 9'd0);
		t.value_q = '1;
		t.value_d = '1;
		t.value_m = '1;
		queue_txn(t);
		t = make_txn(FN_INS_POL, '1, 9'd0, 9'd383);
		t.policy_word = '1;
		queue_txn(t);
		t = make_txn(FN_INS_POL, '1, 9'd0, 9'd0);
		t.policy_word = '0;
		queue_txn(t);
		queue_txn(make_txn(FN_INS_POL, '1, 9'd0, 9'd384));
		queue_txn(make_txn(FN_INS_POL, '1, 9'd0, 9'd511));
		queue_txn(make_txn(FN_LOOKUP, '1, 9'd511, 9'd383));
		queue_txn(make_txn(FN_LOOKUP, '1, 9'd511, 9'd0));
		queue_txn(make_txn(FN_LOOKUP, '1, 9'd511, 9'd384));
		queue_txn(make_txn(FN_LOOKUP, '1, 9'd511, 9'd511));
		queue_txn(make_txn(FN_LOOKUP, '1, 9'd510, 9'd0));
		queue_txn(make_txn(FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 9'd511, 9'd0));
		queue_txn(make_txn(FN_INS_HDR, 64'd256, 9'd5, 9'd0));
		queue_txn(make_txn(FN_INS_POL, 64'd256, 9'd0, 9'd4));
		queue_txn(make_txn(FN_LOOKUP, 64'd256, 9'd5, 9'd4));
		queue_txn(make_txn(FN_LOOKUP, 64'd256, 9'd5, 9'd5));
		queue_txn(make_txn(FN_CLEAR, '1, 9'd0, 9'd0));
		queue_txn(make_txn(FN_LOOKUP, '1, 9'd511, 9'd383));
		queue_txn(make_txn(FN_LOOKUP, '0, 9'd0, 9'd0));
		queue_txn(make_txn(FN_INS_HDR, '0, 9'd0, 9'd0));
		queue_txn(make_txn(FN_LOOKUP, '0, 9'd0, 9'd0));
		random_phase(250);

		for (int i = 0; i < 6; i++) begin
			drain();
			write_size((i == 5) ? SIZE_W'($urandom_range(2, 255)) : size_plan[i]);
			random_phase(phase_len[i]);
		end
		drain();

		if (n_fail == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

FILE: direct_mapped_eval_cache_top.f
hdl/dmec_pkg.sv
hdl/dmec_ram.sv
hdl/dmec_mod.sv
hdl/direct_mapped_eval_cache_top.sv
hdl/dmec_chk.sv
tb/testbench.sv
